// File: sv/prbq_pkg.sv
// Package: shared types and codes of the per-bus request queue.
package prbq_pkg;

  // Item kinds
  localparam logic [1:0] FN_SUBMIT   = 2'd0;
  localparam logic [1:0] FN_RESPONSE = 2'd1;
  localparam logic [1:0] FN_TICK     = 2'd2;

  // Result event codes
  localparam logic [1:0] EV_SUBMIT  = 2'd0;
  localparam logic [1:0] EV_ISSUE   = 2'd1;
  localparam logic [1:0] EV_DONE    = 2'd2;
  localparam logic [1:0] EV_TIMEOUT = 2'd3;

  // Submit status codes
  localparam logic [15:0] ST_OK      = 16'd0;
  localparam logic [15:0] ST_BAD_BUS = 16'd1;
  localparam logic [15:0] ST_FULL    = 16'd2;

  localparam logic [15:0] TIMEOUT_STATUS = 16'hFFFF;
  localparam logic [15:0] RESET_TIMEOUT  = 16'd200;

  // Results one item may cause, and a counter wide enough for it
  localparam int          MAX_RESULTS = 8;
  localparam int          RES_CNT_W   = 4;

  // One queued request
  typedef struct packed {
    logic [7:0]  dev_addr;
    logic [15:0] reg_addr;
    logic [15:0] reg_count;
    logic [7:0]  tag;
  } entry_t;

  // One result beat
  typedef struct packed {
    logic [1:0]  event_res;
    logic [1:0]  bus_res;
    entry_t      req;
    logic [15:0] status;
    logic [7:0]  data_len;
  } rec_t;

endpackage

// File: sv/per_bus_request_queue_with_timeout_top.sv
// Top level: per-bus request queues with response timeout, sequenced around one RAM.
//
// Items are taken one at a time: start is accepted when busy is low. A submit
// whose bus is in range and not full stores its request at the tail and issues
// it at once on an idle bus; a response to an out-of-range or empty bus gives
// no result, and one that matches the head completes it and issues the next
// queued request if there is one; a tick visits every bus in turn, expiring
// timed-out heads and issuing the requests behind them. The sequencer produces
// at most one result per cycle, and each result that carries a request from the
// queue follows a registered read of the queue RAM. Results go out on strobe,
// one beat per cycle, and cannot be held off; each beat is held until the next
// one of the item is formed or the item ends, so the last beat of an item
// appears in the cycle after busy falls. The queue RAM needs no clearing pass:
// a slot is only read after a submit has written it.
module per_bus_request_queue_with_timeout_top #(
  parameter int NUM_BUSES   = 4,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // item input
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [7:0]  bus,
  input  logic [7:0]  dev_addr,
  input  logic [15:0] reg_addr,
  input  logic [15:0] reg_count,
  input  logic [7:0]  tag,
  input  logic [15:0] rsp_status,
  input  logic [7:0]  payload_len,
  // results
  output logic        strobe,
  output logic [1:0]  event_res,
  output logic [1:0]  bus_res,
  output logic [7:0]  dev_addr_res,
  output logic [15:0] reg_addr_res,
  output logic [15:0] reg_count_res,
  output logic [7:0]  tag_res,
  output logic [15:0] status,
  output logic [7:0]  data_len,
  output logic        last,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import prbq_pkg::*;

  localparam int BW        = (NUM_BUSES > 1) ? $clog2(NUM_BUSES) : 1;
  localparam int PW        = $clog2(QUEUE_DEPTH);
  localparam int FW        = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_BUSES * QUEUE_DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_SUB_ST   = 3'd2;
  localparam logic [2:0] S_RSP_CMP  = 3'd3;
  localparam logic [2:0] S_TICK_CHK = 3'd4;
  localparam logic [2:0] S_TICK_RD  = 3'd5;
  localparam logic [2:0] S_ISSUE    = 3'd6;

  function automatic logic [AW-1:0] slot_addr(input logic [BW-1:0] b, input logic [PW-1:0] p);
    return AW'(AW'(b) * AW'(QUEUE_DEPTH) + AW'(p));
  endfunction

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW:0] s;
    s = {1'b0, p} + 1'b1;
    return (s >= (PW+1)'(QUEUE_DEPTH)) ? '0 : s[PW-1:0];
  endfunction

  // Control state
  logic [2:0]           state, state_next;
  logic [BW-1:0]        cur, cur_next;
  logic [RES_CNT_W-1:0] res_n, res_n_next;
  logic [15:0]          timeout_ticks;

  // Per-bus bookkeeping
  logic [PW-1:0] head_ptr   [NUM_BUSES];
  logic [PW-1:0] tail_ptr   [NUM_BUSES];
  logic [FW-1:0] fill_count [NUM_BUSES];
  logic [15:0]   timer_left [NUM_BUSES];

  // Captured item
  logic [1:0]  func_q;
  logic [7:0]  bus_q;
  entry_t      req_q;
  logic [15:0] rsp_status_q;
  logic [7:0]  payload_len_q;

  // Pending result beat
  rec_t pend;
  logic pend_valid;

  // Sequencer outputs
  logic          emit_en;
  rec_t          emit_rec;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t        rd_data;
  logic          head_we, tail_we, fill_we, timer_we;
  logic [PW-1:0] head_wd, tail_wd;
  logic [FW-1:0] fill_wd;
  logic [15:0]   timer_wd;

  // Helpers on the selected bus
  logic [PW-1:0] head_cur, head_inc;
  logic [FW-1:0] fill_cur, fill_dec;
  logic [15:0]   timer_cur;
  logic          bad_bus, scan_last;
  logic [2:0]    done_state;
  logic [BW-1:0] done_cur;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign head_cur  = head_ptr[cur];
  assign head_inc  = ptr_inc(head_cur);
  assign fill_cur  = fill_count[cur];
  assign fill_dec  = fill_cur - 1'b1;
  assign timer_cur = timer_left[cur];
  assign bad_bus   = (bus_q >= 8'(NUM_BUSES));
  assign scan_last = (cur == BW'(NUM_BUSES - 1));

  // Where to go once the selected bus is finished: next bus on a tick, else idle
  always_comb begin
    if (func_q == FN_TICK && !scan_last) begin
      done_state = S_TICK_CHK;
      done_cur   = cur + 1'b1;
    end else begin
      done_state = S_IDLE;
      done_cur   = cur;
    end
  end

  prbq_mem #(
    .DEPTH (MEM_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (req_q),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  // Sequence one item: decode, store at the tail or read the head, emit, advance the queue
  always_comb begin
    state_next = state;
    cur_next   = cur;
    emit_en    = 1'b0;
    emit_rec   = '0;
    mem_we     = 1'b0;
    mem_waddr  = slot_addr(cur, tail_ptr[cur]);
    mem_re     = 1'b0;
    mem_raddr  = slot_addr(cur, head_cur);
    head_we    = 1'b0;
    head_wd    = head_inc;
    tail_we    = 1'b0;
    tail_wd    = ptr_inc(tail_ptr[cur]);
    fill_we    = 1'b0;
    fill_wd    = fill_dec;
    timer_we   = 1'b0;
    timer_wd   = timeout_ticks;

    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DECODE;
          cur_next   = (func == FN_TICK) ? '0 : bus[BW-1:0];
        end
      end

      S_DECODE: begin
        state_next = S_IDLE;
        case (func_q)
          FN_SUBMIT: begin
            emit_en            = 1'b1;
            emit_rec.event_res = EV_SUBMIT;
            if (bad_bus) begin
              emit_rec.status = ST_BAD_BUS;
            end else if (fill_cur >= FW'(QUEUE_DEPTH)) begin
              emit_rec.bus_res = 2'(cur);
              emit_rec.status  = ST_FULL;
            end else begin
              // store at the tail; issue at once on an idle bus
              mem_we  = 1'b1;
              tail_we = 1'b1;
              fill_we = 1'b1;
              fill_wd = fill_cur + 1'b1;
              emit_rec.bus_res = 2'(cur);
              emit_rec.status  = ST_OK;
              if (fill_cur == '0) begin
                timer_we           = 1'b1;
                emit_rec.event_res = EV_ISSUE;
                emit_rec.req       = req_q;
                state_next         = S_SUB_ST;
              end
            end
          end
          FN_RESPONSE: begin
            if (!bad_bus && fill_cur != '0) begin
              mem_re     = 1'b1;
              state_next = S_RSP_CMP;
            end
          end
          FN_TICK: begin
            state_next = S_TICK_CHK;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end

      S_SUB_ST: begin
        emit_en            = 1'b1;
        emit_rec.event_res = EV_SUBMIT;
        emit_rec.bus_res   = 2'(cur);
        emit_rec.status    = ST_OK;
        state_next         = S_IDLE;
      end

      S_RSP_CMP, S_TICK_RD: begin
        if (state == S_TICK_RD || (rd_data.dev_addr == req_q.dev_addr &&
                                   rd_data.reg_addr == req_q.reg_addr)) begin
          emit_en          = 1'b1;
          emit_rec.bus_res = 2'(cur);
          emit_rec.req     = rd_data;
          if (state == S_TICK_RD) begin
            emit_rec.event_res = EV_TIMEOUT;
            emit_rec.status    = TIMEOUT_STATUS;
          end else begin
            emit_rec.event_res = EV_DONE;
            emit_rec.status    = rsp_status_q;
            emit_rec.data_len  = payload_len_q;
          end
          // pop the head; fetch the next one if the queue still holds any
          head_we  = 1'b1;
          fill_we  = 1'b1;
          timer_we = 1'b1;
          if (fill_dec != '0) begin
            mem_re     = 1'b1;
            mem_raddr  = slot_addr(cur, head_inc);
            state_next = S_ISSUE;
          end else begin
            timer_wd   = '0;
            state_next = done_state;
            cur_next   = done_cur;
          end
        end else begin
          state_next = S_IDLE;
        end
      end

      S_TICK_CHK: begin
        state_next = done_state;
        cur_next   = done_cur;
        if (fill_cur != '0) begin
          timer_we = 1'b1;
          if (timer_cur > 16'd1) begin
            timer_wd = timer_cur - 1'b1;
          end else if (res_n <= RES_CNT_W'(MAX_RESULTS - 2)) begin
            timer_we   = 1'b0;
            mem_re     = 1'b1;
            state_next = S_TICK_RD;
            cur_next   = cur;
          end else begin
            // no room for this expiry: hold it for a later tick
            timer_wd = '0;
          end
        end
      end

      S_ISSUE: begin
        emit_en            = 1'b1;
        emit_rec.event_res = EV_ISSUE;
        emit_rec.bus_res   = 2'(cur);
        emit_rec.req       = rd_data;
        state_next         = done_state;
        cur_next           = done_cur;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign res_n_next = res_n + RES_CNT_W'(emit_en);

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cur           <= '0;
      res_n         <= '0;
      timeout_ticks <= RESET_TIMEOUT;
    end else begin
      state <= state_next;
      cur   <= cur_next;
      res_n <= (state == S_IDLE) ? '0 : res_n_next;
      if (cfg_valid && cfg_ready) begin
        timeout_ticks <= cfg_data;
      end
    end
  end

  // Per-bus bookkeeping, one bus updated per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BUSES; i++) begin
        head_ptr[i]   <= '0;
        tail_ptr[i]   <= '0;
        fill_count[i] <= '0;
        timer_left[i] <= '0;
      end
    end else begin
      if (head_we) begin
        head_ptr[cur] <= head_wd;
      end
      if (tail_we) begin
        tail_ptr[cur] <= tail_wd;
      end
      if (fill_we) begin
        fill_count[cur] <= fill_wd;
      end
      if (timer_we) begin
        timer_left[cur] <= timer_wd;
      end
    end
  end

  // Capture the item on accept
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      func_q         <= func;
      bus_q          <= bus;
      req_q.dev_addr <= dev_addr;
      req_q.reg_addr <= reg_addr;
      req_q.reg_count <= reg_count;
      req_q.tag      <= tag;
      rsp_status_q   <= rsp_status;
      payload_len_q  <= payload_len;
    end
  end

  // Result path: hold one beat back so the final beat can carry last
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (emit_en) begin
        pend_valid <= 1'b1;
        strobe     <= pend_valid;
      end else if (state == S_IDLE && pend_valid) begin
        pend_valid <= 1'b0;
        strobe     <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_en) begin
      pend <= emit_rec;
    end
    if (emit_en || state == S_IDLE) begin
      event_res     <= pend.event_res;
      bus_res       <= pend.bus_res;
      dev_addr_res  <= pend.req.dev_addr;
      reg_addr_res  <= pend.req.reg_addr;
      reg_count_res <= pend.req.reg_count;
      tag_res       <= pend.req.tag;
      status        <= pend.status;
      data_len      <= pend.data_len;
      last          <= !emit_en;
    end
  end

  // A head result always follows a RAM read in the cycle before
  ap_read_before_use: assert property (@(posedge clk) disable iff (rst)
    (state == S_RSP_CMP || state == S_TICK_RD || state == S_ISSUE) |-> $past(mem_re))
    else $error("head used without a preceding RAM read");

  // The RAM is only written while decoding a submit
  ap_write_on_submit: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_DECODE && func_q == FN_SUBMIT))
    else $error("queue RAM written outside a submit");

  // An empty queue has no running timer
  ap_idle_timer: assert property (@(posedge clk) disable iff (rst)
    (state == S_TICK_CHK && fill_cur == '0) |-> (timer_cur == '0))
    else $error("timer running on an empty queue");

  // Never more beats per item than allowed
  ap_result_limit: assert property (@(posedge clk) disable iff (rst)
    res_n <= RES_CNT_W'(MAX_RESULTS))
    else $error("too many results for one item");

  // Fill count stays within the queue depth
  ap_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_TICK_CHK) |-> (fill_cur <= FW'(QUEUE_DEPTH)))
    else $error("fill count beyond queue depth");

endmodule

// File: sv/prbq_mem.sv
// Queue storage: one-write, one-read synchronous RAM with registered read data.
module prbq_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  prbq_pkg::entry_t wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output prbq_pkg::entry_t rdata
);
  import prbq_pkg::*;

  entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, read data registered when re is high
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
